FILE: sv/tqs_pkg.sv
// Shared types and constants for the two-queue strict-priority scheduler.
// Used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package tqs_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths fixed by the item format
   localparam int KIND_W    = 2;
   localparam int ID_W      = 16;
   localparam int TIME_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int OCC_W     = 5;
   localparam int STAT_W    = 48;
   localparam int LIMIT_W   = 5;
   localparam int SEL_W     = 4;
   localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_ADMIT_CAP   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_STAT_SELECT = CSR_ADDR_W'(1);
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = LIMIT_W'(16);

   // event counters
   localparam int NUM_EVENTS    = 9;
   localparam int EV_HIGH_REQ   = 0;
   localparam int EV_LOW_REQ    = 1;
   localparam int EV_HIGH_ACC   = 2;
   localparam int EV_LOW_ACC    = 3;
   localparam int EV_HIGH_REF   = 4;
   localparam int EV_LOW_REF    = 5;
   localparam int EV_HIGH_SERV  = 6;
   localparam int EV_LOW_SERV   = 7;
   localparam int EV_IDLE_TICK  = 8;
   localparam logic [SEL_W-1:0] SEL_WAIT_HIGH = SEL_W'(9);
   localparam logic [SEL_W-1:0] SEL_WAIT_LOW  = SEL_W'(10);

   typedef enum logic [KIND_W-1:0] {
      KIND_HIGH = 2'd0,
      KIND_LOW  = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED    = 3'd0,
      ST_REFUSED     = 3'd1,
      ST_SERVED_HIGH = 3'd2,
      ST_SERVED_LOW  = 3'd3,
      ST_IDLE        = 3'd4
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
   } sts_type;

   // one queue entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
   } entry_type;

endpackage

`default_nettype wire

FILE: sv/tqs_req_if.sv
// Request channel: valid/ready handshake with kind, id and time.
// Depends on tqs_pkg for field widths.
`default_nettype none

interface tqs_req_if
   import tqs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   req_id;
   logic [TIME_W-1:0] now;

   modport source (output valid, output kind, output req_id, output now, input ready);
   modport sink   (input valid, input kind, input req_id, input now, output ready);
endinterface

`default_nettype wire

FILE: sv/tqs_rsp_if.sv
// Result channel: valid/ready handshake with the served entry and statistics.
// Depends on tqs_pkg for field widths.
`default_nettype none

interface tqs_rsp_if
   import tqs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     served_id;
   logic [TIME_W-1:0]   served_arrival;
   logic [TIME_W-1:0]   wait_res;
   logic [OCC_W-1:0]    high_count;
   logic [OCC_W-1:0]    low_count;
   logic [STAT_W-1:0]   stat_value;

   modport source (output valid, output status, output served_id, output served_arrival,
                   output wait_res, output high_count, output low_count,
                   output stat_value, input ready);
   modport sink   (input valid, input status, input served_id, input served_arrival,
                   input wait_res, input high_count, input low_count,
                   input stat_value, output ready);
endinterface

`default_nettype wire

FILE: sv/tqs_csr_if.sv
// Configuration write channel: valid/ready with register address and data.
// Depends on tqs_pkg for widths.
`default_nettype none

interface tqs_csr_if
   import tqs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/tqs_ctrl.sv
// Scheduler controller: sequences accept and execute of one item at a time.
// Depends on tqs_pkg for state, command and status types.
`default_nettype none

module tqs_ctrl
   import tqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CS_EXEC;
            end
         end
         CS_EXEC: begin
            // wait for room in the result register
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/tqs_dp.sv
// Scheduler datapath: queue memories, pointers, statistics and result register.
// Depends on tqs_pkg and the request, result and configuration interfaces.
`default_nettype none

module tqs_dp
   import tqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output sts_type      sts,
   tqs_req_if.sink      req_ch,
   tqs_rsp_if.source    rsp_ch,
   tqs_csr_if.sink      csr_ch
);

   // configuration
   logic [LIMIT_W-1:0] admit_cap_ff;
   logic [SEL_W-1:0]   stat_select_ff;

   // captured item
   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]   req_id_ff;
   logic [TIME_W-1:0] now_ff;

   // queues
   entry_type        hq_mem [QUEUE_DEPTH];
   entry_type        lq_mem [QUEUE_DEPTH];
   entry_type        hq_rd_ff;
   entry_type        lq_rd_ff;
   logic [IDX_W-1:0] hq_head_ff, hq_head_in, hq_tail_ff, hq_tail_in;
   logic [IDX_W-1:0] lq_head_ff, lq_head_in, lq_tail_ff, lq_tail_in;
   logic [CNT_W-1:0] hq_cnt_ff, hq_cnt_in, lq_cnt_ff, lq_cnt_in;

   // statistics
   logic [TIME_W-1:0] evt_ff [NUM_EVENTS];
   logic [TIME_W-1:0] evt_in [NUM_EVENTS];
   logic [STAT_W-1:0] hsum_ff, hsum_in, lsum_ff, lsum_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     sid_ff;
   logic [TIME_W-1:0]   sarr_ff;
   logic [TIME_W-1:0]   wait_ff;
   logic [OCC_W-1:0]    hcnt_out_ff, lcnt_out_ff;
   logic [STAT_W-1:0]   stat_ff;

   // step decode
   logic [NUM_EVENTS-1:0] inc;
   logic                  push_h, push_l, pop_h, pop_l;
   status_type            status_c;
   entry_type             served_c;
   logic [TIME_W-1:0]     wait_c;
   logic [LIM_CMP_W-1:0]  lim_ext, eff_limit;
   logic                  h_room, l_room;
   logic [LIM_CMP_W-1:0]  hcnt_ext, lcnt_ext;
   logic [STAT_W-1:0]     stat_c;

   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] ptr);
      next_ptr = (ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + IDX_W'(1);
   endfunction

   assign csr_ch.ready  = 1'b1;
   assign sts.slot_free = !out_valid_ff || rsp_ch.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         admit_cap_ff   <= LIMIT_RESET;
         stat_select_ff <= '0;
      end else if (csr_ch.valid) begin
         if (csr_ch.addr == REG_ADMIT_CAP) begin
            admit_cap_ff <= csr_ch.data[LIMIT_W-1:0];
         end
         if (csr_ch.addr == REG_STAT_SELECT) begin
            stat_select_ff <= csr_ch.data[SEL_W-1:0];
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_ch.kind;
         req_id_ff <= req_ch.req_id;
         now_ff    <= req_ch.now;
      end
   end

   // queue memories: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (push_h) begin
         hq_mem[hq_tail_ff] <= '{id: req_id_ff, arrival: now_ff};
      end
      if (push_l) begin
         lq_mem[lq_tail_ff] <= '{id: req_id_ff, arrival: now_ff};
      end
      hq_rd_ff <= hq_mem[hq_head_ff];
      lq_rd_ff <= lq_mem[lq_head_ff];
   end

   // admission limit, clipped to the queue depth
   always_comb begin
      lim_ext   = LIM_CMP_W'(admit_cap_ff);
      eff_limit = (lim_ext > LIM_CMP_W'(QUEUE_DEPTH)) ? LIM_CMP_W'(QUEUE_DEPTH) : lim_ext;
      h_room    = LIM_CMP_W'(hq_cnt_ff) < eff_limit;
      l_room    = LIM_CMP_W'(lq_cnt_ff) < eff_limit;
   end

   // decode of the captured item
   always_comb begin
      inc      = '0;
      push_h   = 1'b0;
      push_l   = 1'b0;
      pop_h    = 1'b0;
      pop_l    = 1'b0;
      status_c = ST_IDLE;
      served_c = '0;
      case (kind_ff)
         KIND_HIGH: begin
            inc[EV_HIGH_REQ] = 1'b1;
            if (h_room) begin
               inc[EV_HIGH_ACC] = 1'b1;
               push_h           = cmd.commit;
               status_c         = ST_ACCEPTED;
            end else begin
               inc[EV_HIGH_REF] = 1'b1;
               status_c         = ST_REFUSED;
            end
         end
         KIND_LOW: begin
            inc[EV_LOW_REQ] = 1'b1;
            if (l_room) begin
               inc[EV_LOW_ACC] = 1'b1;
               push_l          = cmd.commit;
               status_c        = ST_ACCEPTED;
            end else begin
               inc[EV_LOW_REF] = 1'b1;
               status_c        = ST_REFUSED;
            end
         end
         KIND_TICK: begin
            // strict priority: high head first
            if (hq_cnt_ff != '0) begin
               inc[EV_HIGH_SERV] = 1'b1;
               pop_h             = cmd.commit;
               served_c          = hq_rd_ff;
               status_c          = ST_SERVED_HIGH;
            end else if (lq_cnt_ff != '0) begin
               inc[EV_LOW_SERV] = 1'b1;
               pop_l            = cmd.commit;
               served_c         = lq_rd_ff;
               status_c         = ST_SERVED_LOW;
            end else begin
               inc[EV_IDLE_TICK] = 1'b1;
            end
         end
         default: begin
            // unused kind: no state change, idle result
            status_c = ST_IDLE;
         end
      endcase
      wait_c = (status_c == ST_SERVED_HIGH || status_c == ST_SERVED_LOW) ?
               now_ff - served_c.arrival : '0;
   end

   // next pointers, occupancies and statistics
   always_comb begin
      hq_head_in = pop_h  ? next_ptr(hq_head_ff) : hq_head_ff;
      hq_tail_in = push_h ? next_ptr(hq_tail_ff) : hq_tail_ff;
      lq_head_in = pop_l  ? next_ptr(lq_head_ff) : lq_head_ff;
      lq_tail_in = push_l ? next_ptr(lq_tail_ff) : lq_tail_ff;
      hq_cnt_in  = hq_cnt_ff + CNT_W'(push_h) - CNT_W'(pop_h);
      lq_cnt_in  = lq_cnt_ff + CNT_W'(push_l) - CNT_W'(pop_l);
      for (int i = 0; i < NUM_EVENTS; i++) begin
         evt_in[i] = evt_ff[i] + TIME_W'(inc[i] && cmd.commit);
      end
      hsum_in  = pop_h ? hsum_ff + STAT_W'(wait_c) : hsum_ff;
      lsum_in  = pop_l ? lsum_ff + STAT_W'(wait_c) : lsum_ff;
      hcnt_ext = LIM_CMP_W'(hq_cnt_in);
      lcnt_ext = LIM_CMP_W'(lq_cnt_in);
   end

   // statistics selection, after this step's update
   always_comb begin
      if (stat_select_ff < SEL_W'(NUM_EVENTS)) begin
         stat_c = STAT_W'(evt_in[stat_select_ff]);
      end else if (stat_select_ff == SEL_WAIT_HIGH) begin
         stat_c = hsum_in;
      end else if (stat_select_ff == SEL_WAIT_LOW) begin
         stat_c = lsum_in;
      end else begin
         stat_c = '0;
      end
   end

   // control state: pointers, counts, counters and wait sums
   always_ff @(posedge clock) begin
      if (reset) begin
         hq_head_ff <= '0;
         hq_tail_ff <= '0;
         lq_head_ff <= '0;
         lq_tail_ff <= '0;
         hq_cnt_ff  <= '0;
         lq_cnt_ff  <= '0;
         hsum_ff    <= '0;
         lsum_ff    <= '0;
         for (int i = 0; i < NUM_EVENTS; i++) begin
            evt_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         hq_head_ff <= hq_head_in;
         hq_tail_ff <= hq_tail_in;
         lq_head_ff <= lq_head_in;
         lq_tail_ff <= lq_tail_in;
         hq_cnt_ff  <= hq_cnt_in;
         lq_cnt_ff  <= lq_cnt_in;
         hsum_ff    <= hsum_in;
         lsum_ff    <= lsum_in;
         for (int i = 0; i < NUM_EVENTS; i++) begin
            evt_ff[i] <= evt_in[i];
         end
      end
   end

   // result register valid
   always_comb begin
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status_c;
         sid_ff      <= served_c.id;
         sarr_ff     <= served_c.arrival;
         wait_ff     <= wait_c;
         hcnt_out_ff <= hcnt_ext[OCC_W-1:0];
         lcnt_out_ff <= lcnt_ext[OCC_W-1:0];
         stat_ff     <= stat_c;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.served_id      = sid_ff;
   assign rsp_ch.served_arrival = sarr_ff;
   assign rsp_ch.wait_res       = wait_ff;
   assign rsp_ch.high_count     = hcnt_out_ff;
   assign rsp_ch.low_count      = lcnt_out_ff;
   assign rsp_ch.stat_value     = stat_ff;

endmodule

`default_nettype wire

FILE: sv/two_queue_priority_scheduler.sv
// Top level of the two-queue strict-priority scheduler.
// Depends on tqs_pkg, the three channel interfaces, tqs_ctrl and tqs_dp.
//
//   channel  | dir | carries
//   ---------+-----+--------------------------------------------------------
//   req_ch   | in  | kind, req_id, now
//   rsp_ch   | out | status, served_id, served_arrival, wait_res, counts, stat
//   csr_ch   | in  | addr (0 admit cap, 1 stat_select), data
//
// Each item is first accepted, while the queue heads are read from the queue
// memories into registers, and then executed, loading the result register.
// The registered head read of the queue memories is why execution is a separate state.
// Reset clears pointers, occupancies, counters and sums at once; there is no
// clearing pass. The result register holds a finished item while the next is
// accepted; execution waits only while that register is full and not taken.
`default_nettype none

module two_queue_priority_scheduler
   import tqs_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   tqs_req_if.sink   req_ch,
   tqs_rsp_if.source rsp_ch,
   tqs_csr_if.sink   csr_ch
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   tqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // queues, statistics and result register
   tqs_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

`default_nettype wire
